>>> hdl/rpd_pkg.sv
package rpd_pkg;

  // fixed field widths
  localparam int unsigned ConnIdW  = 3;
  localparam int unsigned RssiW    = 8;
  localparam int unsigned TolW     = 7;
  localparam int unsigned CntW     = 8;
  localparam int unsigned EventW   = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // register reset values
  localparam logic signed [RssiW-1:0] NearThresholdReset = -8'sd65;
  localparam logic [TolW-1:0]         ToleranceReset     = 7'd5;
  localparam logic [CntW-1:0]         CountLimitReset    = 8'd5;

  typedef enum logic [EventW-1:0] {
    EV_NONE     = 2'd0,
    EV_DETECTED = 2'd1,
    EV_LOST     = 2'd2
  } event_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NEAR_THRESHOLD = 2'd0,
    REG_TOLERANCE      = 2'd1,
    REG_COUNT_LIMIT    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic                    op;
    logic [ConnIdW-1:0]      conn_id;
    logic                    connected;
    logic signed [RssiW-1:0] rssi_dbm;
    logic                    last_of_sweep;
  } sample_t;

  typedef struct packed {
    event_e event_res;
    logic   any_detected;
    logic   keep_polling;
  } result_t;

  typedef struct packed {
    logic signed [RssiW-1:0] near_threshold_dbm;
    logic [TolW-1:0]         tolerance_dbm;
    logic [CntW-1:0]         count_limit;
  } cfg_t;

  // counter increment that holds at full scale
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    sat_inc = (c == {CntW{1'b1}}) ? c : c + CntW'(1);
  endfunction

endpackage

>>> hdl/rpd_ifs.sv
interface rpd_sample_if import rpd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [ConnIdW-1:0]      conn_id;
  logic                    connected;
  logic signed [RssiW-1:0] rssi_dbm;
  logic                    last_of_sweep;

  modport source (
    output valid, op, conn_id, connected, rssi_dbm, last_of_sweep,
    input  ready
  );
  modport sink (
    input  valid, op, conn_id, connected, rssi_dbm, last_of_sweep,
    output ready
  );
  modport monitor (
    input valid, ready, op, conn_id, connected, rssi_dbm, last_of_sweep
  );
endinterface

interface rpd_result_if import rpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_res;
  logic              any_detected;
  logic              keep_polling;

  modport source (
    output valid, event_res, any_detected, keep_polling,
    input  ready
  );
  modport sink (
    input  valid, event_res, any_detected, keep_polling,
    output ready
  );
  modport monitor (
    input valid, ready, event_res, any_detected, keep_polling
  );
endinterface

>>> hdl/rpd_update.sv
module rpd_update import rpd_pkg::*; #(
  parameter int unsigned NUM_CONNS = 4
) (
  input  sample_t              smp_i,
  input  cfg_t                 cfg_i,
  input  logic [CntW-1:0]      near_cnt_i [NUM_CONNS],
  input  logic [CntW-1:0]      far_cnt_i  [NUM_CONNS],
  input  logic [NUM_CONNS-1:0] flags_i,
  input  logic                 saw_link_i,
  output logic [CntW-1:0]      near_cnt_o [NUM_CONNS],
  output logic [CntW-1:0]      far_cnt_o  [NUM_CONNS],
  output logic [NUM_CONNS-1:0] flags_o,
  output logic                 saw_link_o,
  output result_t              res_o
);

  logic                  conn_ok;
  logic [NUM_CONNS-1:0]  sel;
  logic [CntW-1:0]       near_cur;
  logic [CntW-1:0]       far_cur;
  logic [CntW-1:0]       near_new;
  logic [CntW-1:0]       far_new;
  logic                  is_near;
  logic                  is_far;
  logic signed [RssiW:0] far_limit;
  event_e                ev;
  logic                  keep;

  assign conn_ok = int'(smp_i.conn_id) < int'(NUM_CONNS);

  always_comb begin
    near_cur = '0;
    far_cur  = '0;
    for (int i = 0; i < NUM_CONNS; i++) begin
      sel[i]   = conn_ok && (smp_i.conn_id == ConnIdW'(i));
      near_cur = near_cur | (sel[i] ? near_cnt_i[i] : '0);
      far_cur  = far_cur  | (sel[i] ? far_cnt_i[i]  : '0);
    end
  end

  // far bound can drop below -128, so one extra bit
  assign far_limit = $signed({cfg_i.near_threshold_dbm[RssiW-1], cfg_i.near_threshold_dbm})
                   - $signed({2'b00, cfg_i.tolerance_dbm});
  assign is_near   = smp_i.rssi_dbm >= cfg_i.near_threshold_dbm;
  assign is_far    = $signed({smp_i.rssi_dbm[RssiW-1], smp_i.rssi_dbm}) <= far_limit;
  assign near_new  = is_near ? sat_inc(near_cur) : '0;
  assign far_new   = is_far  ? sat_inc(far_cur)  : '0;

  always_comb begin
    near_cnt_o = near_cnt_i;
    far_cnt_o  = far_cnt_i;
    flags_o    = flags_i;
    saw_link_o = saw_link_i;
    ev         = EV_NONE;
    keep       = 1'b0;

    if (smp_i.op == OP_CLEAR) begin
      for (int i = 0; i < NUM_CONNS; i++) begin
        if (sel[i]) begin
          near_cnt_o[i] = '0;
          far_cnt_o[i]  = '0;
        end
      end
    end else begin
      if (conn_ok) begin
        if (smp_i.connected) begin
          saw_link_o = 1'b1;
          for (int i = 0; i < NUM_CONNS; i++) begin
            if (sel[i]) begin
              near_cnt_o[i] = near_new;
              far_cnt_o[i]  = far_new;
            end
          end
          if (near_new >= cfg_i.count_limit) begin
            if (flags_i == '0) ev = EV_DETECTED;
            flags_o = flags_i | sel;
          end else if (far_new >= cfg_i.count_limit) begin
            if ((flags_i & sel) != '0) begin
              flags_o = flags_i & ~sel;
              if (flags_o == '0) ev = EV_LOST;
            end
          end
        end else begin
          // link down: drop the flag quietly
          flags_o = flags_i & ~sel;
        end
      end
      if (smp_i.last_of_sweep) begin
        if (saw_link_o) keep = 1'b1;
        else            ev   = EV_LOST;
        saw_link_o = 1'b0;
      end
    end
  end

  assign res_o.event_res    = ev;
  assign res_o.any_detected = |flags_o;
  assign res_o.keep_polling = keep;

endmodule

>>> hdl/rssi_proximity_detector.sv
// rssi proximity detector: debounced near/far tracking of link rssi with hysteresis
//
// sample_i carries one item per transfer: an rssi sample for one connection, or a
// clear op that zeroes that connection's near/far counters. result_o returns
// exactly one item per input: an event (none, detected, lost), whether any
// connection is flagged near, and on the last sample of a sweep whether any
// link was up.
// the cfg port writes threshold, tolerance and count limit; write only while idle.
//
// result path: the sample is registered in the input register, the counter/flag
// update is combinational, and its result is registered in the result register
// throughput: one item per cycle while result_o is taken; the per-connection
// counters and flags live in flip-flops and are read and written in the same
// cycle, so back-to-back samples for the same connection see each other's updates
// reset: counters, flags and sweep state clear, registers go to -65 / 5 / 5,
// both pipeline stages empty
// stall: if result_o is not taken, the result register holds, the input
// register holds behind it, and sample_i.ready drops once both are full
module rssi_proximity_detector import rpd_pkg::*; #(
  parameter int unsigned NUM_CONNS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rpd_sample_if.sink          sample_i,
  rpd_result_if.source        result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // config registers
  cfg_t cfg_q;

  // input stage
  logic    in_valid_q;
  sample_t in_q;

  // per-connection state
  logic [CntW-1:0]      near_cnt_q [NUM_CONNS];
  logic [CntW-1:0]      far_cnt_q  [NUM_CONNS];
  logic [CntW-1:0]      near_cnt_d [NUM_CONNS];
  logic [CntW-1:0]      far_cnt_d  [NUM_CONNS];
  logic [NUM_CONNS-1:0] flags_q, flags_d;
  logic                 saw_link_q, saw_link_d;

  // result stage
  logic    out_valid_q;
  result_t out_q, out_d;

  logic advance;
  logic in_xfer;
  logic do_update;

  // the result register frees up when empty or being taken
  assign advance   = !out_valid_q || result_o.ready;
  assign sample_i.ready = !in_valid_q || advance;
  assign in_xfer   = sample_i.valid && sample_i.ready;
  assign do_update = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_threshold_dbm <= NearThresholdReset;
      cfg_q.tolerance_dbm      <= ToleranceReset;
      cfg_q.count_limit        <= CountLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NEAR_THRESHOLD: cfg_q.near_threshold_dbm <= $signed(cfg_wdata_i[RssiW-1:0]);
        REG_TOLERANCE:      cfg_q.tolerance_dbm      <= cfg_wdata_i[TolW-1:0];
        REG_COUNT_LIMIT:    cfg_q.count_limit        <= cfg_wdata_i[CntW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q.op            <= sample_i.op;
      in_q.conn_id       <= sample_i.conn_id;
      in_q.connected     <= sample_i.connected;
      in_q.rssi_dbm      <= sample_i.rssi_dbm;
      in_q.last_of_sweep <= sample_i.last_of_sweep;
    end
  end

  rpd_update #(
    .NUM_CONNS (NUM_CONNS)
  ) u_update (
    .smp_i      (in_q),
    .cfg_i      (cfg_q),
    .near_cnt_i (near_cnt_q),
    .far_cnt_i  (far_cnt_q),
    .flags_i    (flags_q),
    .saw_link_i (saw_link_q),
    .near_cnt_o (near_cnt_d),
    .far_cnt_o  (far_cnt_d),
    .flags_o    (flags_d),
    .saw_link_o (saw_link_d),
    .res_o      (out_d)
  );

  // state commits only when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CONNS; i++) begin
        near_cnt_q[i] <= '0;
        far_cnt_q[i]  <= '0;
      end
      flags_q    <= '0;
      saw_link_q <= 1'b0;
    end else if (do_update) begin
      near_cnt_q <= near_cnt_d;
      far_cnt_q  <= far_cnt_d;
      flags_q    <= flags_d;
      saw_link_q <= saw_link_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_update) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.event_res    = out_q.event_res;
  assign result_o.any_detected = out_q.any_detected;
  assign result_o.keep_polling = out_q.keep_polling;

endmodule

>>> hdl/rpd_checker.sv
module rpd_checker import rpd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [EventW-1:0] event_res_i,
  input logic              any_detected_i,
  input logic              keep_polling_i
);

  // a stalled result keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(event_res_i)
      && $stable(any_detected_i) && $stable(keep_polling_i))
    else $error("result changed while stalled");

  // a fresh result follows an input transfer through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result appeared without a matching input transfer");

  // detection means some connection is flagged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_res_i == EV_DETECTED) |-> any_detected_i)
    else $error("detected event with no near flag");

  // reset empties the result register
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result valid out of reset");

endmodule

bind rssi_proximity_detector rpd_checker u_rpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (sample_i.valid),
  .in_ready_i     (sample_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .event_res_i    (result_o.event_res),
  .any_detected_i (result_o.any_detected),
  .keep_polling_i (result_o.keep_polling)
);
